FILE: hw/rtl/gdrc_pkg.sv
// Shared types and constants for the tile strength grid core.
// Field widths, register indexes, word structs and the sequencer states.
// No dependencies.
`default_nettype none

package gdrc_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;
    localparam int KINDS_DEF       = 2;

    localparam int SIZE_W     = 13;
    localparam int POS_W      = 16;
    localparam int STR_W      = 16;
    localparam int TILE_VAL_W = 32;
    localparam int TOTAL_W    = 44;
    localparam int MEAN_W     = 18;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;
    localparam logic [MEAN_W-1:0]  MEAN_MAX        = '1;
    localparam logic [SIZE_W-1:0]  TILE_SIZE_RESET = 13'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;

    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    typedef struct packed {
        logic                    op;
        logic signed [POS_W-1:0] x_a;
        logic signed [POS_W-1:0] y_a;
        logic signed [POS_W-1:0] x_b;
        logic signed [POS_W-1:0] y_b;
        logic [STR_W-1:0]        strength;
        logic                    kind;
    } req_word_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] box_total;
        logic [MEAN_W-1:0]  mean_x;
        logic [MEAN_W-1:0]  mean_y;
    } rsp_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [SIZE_W-1:0]    value;
    } cfg_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ADDR,
        ST_DEP_RD,
        ST_DEP_WR,
        ST_WALK,
        ST_DRAIN,
        ST_MUL,
        ST_MDIV_START,
        ST_MDIV_WAIT,
        ST_FIN
    } gdrc_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gdrc_if.sv
// Valid/ready channel interfaces for request, response and config words.
// Depends on gdrc_pkg for the word structs.
`default_nettype none

interface gdrc_req_if;
    import gdrc_pkg::*;
    logic      valid;
    logic      ready;
    req_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gdrc_rsp_if;
    import gdrc_pkg::*;
    logic      valid;
    logic      ready;
    rsp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gdrc_cfg_if;
    import gdrc_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gdrc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used for tile index and weighted mean divisions.
`default_nettype none

module gdrc_div #(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              done,
    output logic [W-1:0]      quo
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [W:0]    rem_sh;
    logic          ge;
    logic [W:0]    rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/grid_deposit_region_centroid_core.sv
// Tile strength grid: point deposits with saturation, box queries returning
// the total strength and the strength-weighted tile-centre mean per axis.
// Depends on gdrc_pkg, gdrc_if and gdrc_div.
//
// After reset the tile memory (GRID_WIDTH*GRID_HEIGHT*KINDS words, 8192 at the
// defaults) is zeroed one word per cycle; requests are held off until the
// clear is done, while config writes are taken. Each item first runs its tile
// index divisions on the shared P-bit bit-serial divider (P = 64 at the
// defaults): two for a deposit, four for a query. A deposit then does its
// read-modify-write through ST_DEP_RD and ST_DEP_WR. A query walks the
// clamped box one tile per cycle through the single memory read port, drains
// the read pipeline, and for a nonzero total runs per axis a shift-add multiply
// and one more division. Config is always ready. A finished result sits in an
// output register while the next request is taken.
`default_nettype none

module grid_deposit_region_centroid_core #(
    parameter int GRID_WIDTH  = gdrc_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gdrc_pkg::GRID_HEIGHT_DEF,
    parameter int KINDS       = gdrc_pkg::KINDS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gdrc_req_if.sink   req,
    gdrc_rsp_if.source rsp,
    gdrc_cfg_if.sink   cfg
);
    import gdrc_pkg::*;

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT * KINDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int NT    = GRID_WIDTH * GRID_HEIGHT;
    localparam int TOT_W = TILE_VAL_W + ((NT > 1) ? $clog2(NT) : 1);
    localparam int CRD_W = (XW > YW) ? XW : YW;
    localparam int WS_W  = TOT_W + CRD_W + 1;
    localparam int PW    = WS_W + SIZE_W;
    localparam int TS_W  = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;
    localparam int PX_W  = TILE_VAL_W + XW + 1;
    localparam int PY_W  = TILE_VAL_W + YW + 1;

    gdrc_state_t state_reg, state_next;

    logic [SIZE_W-1:0]     tw_reg, th_reg;
    req_word_t             item_reg;
    logic [1:0]            sel_reg;
    logic [POS_W-1:0]      qmag_reg [4];
    logic                  qneg_reg [4];
    logic [AW-1:0]         addr_reg, row_reg, clr_reg;
    logic [XW-1:0]         wx_reg, lx_reg, rxl_reg, p1_x_reg;
    logic [YW-1:0]         wy_reg, ryl_reg, p1_y_reg;
    logic                  p1_valid_reg, p2_valid_reg;
    logic [TILE_VAL_W-1:0] rd_data_reg, p2_s_reg;
    logic [PX_W-1:0]       p2_wx_reg;
    logic [PY_W-1:0]       p2_wy_reg;
    logic [TOT_W-1:0]      tot_reg;
    logic [WS_W-1:0]       wsx_reg, wsy_reg;
    logic                  axis_reg;
    logic [3:0]            mbit_reg;
    logic [PW-1:0]         mul_reg;
    logic [MEAN_W-1:0]     mx_reg, my_reg;
    logic                  rsp_valid_reg;
    rsp_word_t             rsp_data_reg;

    logic [TILE_VAL_W-1:0] mem [DEPTH];

    logic                  mem_rd_en, mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [TILE_VAL_W-1:0] mem_wr_data;
    logic                  div_start, div_done;
    logic [PW-1:0]         div_num, div_den, div_quo;

    logic [SIZE_W-1:0]     tw_eff, th_eff, div_size, mul_size;
    logic [POS_W-1:0]      pos_sel;
    logic [POS_W:0]        pos_abs;
    logic [1:0]            sel_last;
    logic [POS_W-1:0]      lx16, ly16, rxl16, ryl16;
    logic                  kind_ok, box_empty, walk_ok, dep_ok;
    logic [AW-1:0]         ky_aw, base_aw;
    logic [TILE_VAL_W:0]   dep_sum;
    logic [TILE_VAL_W-1:0] dep_val;
    logic                  x_last, y_last, out_free;
    logic [MEAN_W-1:0]     mean_sat;
    logic [TS_W-1:0]       tot_ext;
    logic [TOTAL_W-1:0]    tot_sat;
    logic [WS_W-1:0]       wsum;

    gdrc_div #(
        .W(PW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        tw_eff = (tw_reg == '0) ? SIZE_W'(1) : tw_reg;
        th_eff = (th_reg == '0) ? SIZE_W'(1) : th_reg;
        case (sel_reg)
            2'd0:    pos_sel = item_reg.x_a;
            2'd1:    pos_sel = item_reg.y_a;
            2'd2:    pos_sel = item_reg.x_b;
            default: pos_sel = item_reg.y_b;
        endcase
        div_size = sel_reg[0] ? th_eff : tw_eff;
        pos_abs  = pos_sel[POS_W-1] ? ((POS_W+1)'(0) - {pos_sel[POS_W-1], pos_sel})
                                    : {1'b0, pos_sel};
        sel_last = (item_reg.op == OP_QUERY) ? 2'd3 : 2'd1;

        lx16  = qneg_reg[0] ? '0 : qmag_reg[0];
        ly16  = qneg_reg[1] ? '0 : qmag_reg[1];
        rxl16 = (qmag_reg[2] > POS_W'(GRID_WIDTH - 1)) ? POS_W'(GRID_WIDTH - 1) : qmag_reg[2];
        ryl16 = (qmag_reg[3] > POS_W'(GRID_HEIGHT - 1)) ? POS_W'(GRID_HEIGHT - 1) : qmag_reg[3];
        kind_ok   = 32'(item_reg.kind) < 32'(KINDS);
        box_empty = qneg_reg[2] || qneg_reg[3] || (lx16 > rxl16) || (ly16 > ryl16);
        walk_ok   = kind_ok && !box_empty;
        dep_ok    = kind_ok && !qneg_reg[0] && !qneg_reg[1]
                    && (qmag_reg[0] < POS_W'(GRID_WIDTH))
                    && (qmag_reg[1] < POS_W'(GRID_HEIGHT));

        ky_aw   = (item_reg.kind ? AW'(GRID_HEIGHT) : AW'(0)) + AW'(ly16[YW-1:0]);
        base_aw = AW'(ky_aw * AW'(GRID_WIDTH)) + AW'(lx16[XW-1:0]);

        dep_sum = {1'b0, rd_data_reg} + (TILE_VAL_W+1)'(item_reg.strength);
        dep_val = dep_sum[TILE_VAL_W] ? '1 : dep_sum[TILE_VAL_W-1:0];

        x_last = wx_reg == rxl_reg;
        y_last = wy_reg == ryl_reg;

        mul_size = axis_reg ? th_eff : tw_eff;
        wsum     = axis_reg ? wsy_reg : wsx_reg;
        mean_sat = (div_quo > PW'(MEAN_MAX)) ? MEAN_MAX : div_quo[MEAN_W-1:0];
        tot_ext  = TS_W'(tot_reg);
        tot_sat  = (tot_ext > TS_W'(TOTAL_MAX)) ? TOTAL_MAX : tot_ext[TOTAL_W-1:0];
        out_free = !rsp_valid_reg || rsp.ready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (req.valid)
                    state_next = ST_DIV_START;
            ST_DIV_START:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                    state_next = (sel_reg == sel_last) ? ST_ADDR : ST_DIV_START;
            ST_ADDR:
                if (item_reg.op == OP_QUERY)
                    state_next = walk_ok ? ST_WALK : ST_FIN;
                else
                    state_next = dep_ok ? ST_DEP_RD : ST_IDLE;
            ST_DEP_RD:
                state_next = ST_DEP_WR;
            ST_DEP_WR:
                state_next = ST_IDLE;
            ST_WALK:
                if (x_last && y_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!p1_valid_reg && !p2_valid_reg)
                    state_next = (tot_reg == '0) ? ST_FIN : ST_MUL;
            ST_MUL:
                if (mbit_reg == '0)
                    state_next = ST_MDIV_START;
            ST_MDIV_START:
                state_next = ST_MDIV_WAIT;
            ST_MDIV_WAIT:
                if (div_done)
                    state_next = axis_reg ? ST_FIN : ST_MUL;
            ST_FIN:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready   = state_reg == ST_IDLE;
        cfg.ready   = 1'b1;
        mem_rd_en   = (state_reg == ST_WALK) || (state_reg == ST_DEP_RD);
        mem_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_DEP_WR);
        mem_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : addr_reg;
        mem_wr_data = (state_reg == ST_CLEAR) ? '0 : dep_val;
        div_start   = (state_reg == ST_DIV_START) || (state_reg == ST_MDIV_START);
        if (state_reg == ST_MDIV_START)
        begin
            div_num = mul_reg;
            div_den = PW'({tot_reg, 1'b0});
        end
        else
        begin
            div_num = PW'(pos_abs);
            div_den = PW'(div_size);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            tw_reg        <= TILE_SIZE_RESET;
            th_reg        <= TILE_SIZE_RESET;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.data.index)
                    CFG_TILE_WIDTH:  tw_reg <= cfg.data.value;
                    CFG_TILE_HEIGHT: th_reg <= cfg.data.value;
                    default:         ;
                endcase
            end
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if ((state_reg == ST_FIN) && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            p1_valid_reg <= state_reg == ST_WALK;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (req.valid)
                begin
                    item_reg <= req.data;
                    sel_reg  <= '0;
                end
            ST_DIV_WAIT:
                if (div_done)
                begin
                    qmag_reg[sel_reg] <= div_quo[POS_W-1:0];
                    qneg_reg[sel_reg] <= pos_sel[POS_W-1] && (div_quo != '0);
                    sel_reg           <= sel_reg + 1'b1;
                end
            ST_ADDR:
            begin
                addr_reg <= base_aw;
                row_reg  <= base_aw;
                wx_reg   <= lx16[XW-1:0];
                lx_reg   <= lx16[XW-1:0];
                wy_reg   <= ly16[YW-1:0];
                rxl_reg  <= rxl16[XW-1:0];
                ryl_reg  <= ryl16[YW-1:0];
                axis_reg <= 1'b0;
                mbit_reg <= 4'(SIZE_W - 1);
                mul_reg  <= '0;
                mx_reg   <= '0;
                my_reg   <= '0;
            end
            ST_WALK:
                if (x_last)
                begin
                    wx_reg   <= lx_reg;
                    wy_reg   <= wy_reg + 1'b1;
                    row_reg  <= row_reg + AW'(GRID_WIDTH);
                    addr_reg <= row_reg + AW'(GRID_WIDTH);
                end
                else
                begin
                    wx_reg   <= wx_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                end
            ST_MUL:
            begin
                mul_reg  <= (mul_reg << 1) + (mul_size[mbit_reg] ? PW'(wsum) : PW'(0));
                mbit_reg <= mbit_reg - 1'b1;
            end
            ST_MDIV_WAIT:
                if (div_done)
                begin
                    if (!axis_reg)
                    begin
                        mx_reg   <= mean_sat;
                        axis_reg <= 1'b1;
                        mbit_reg <= 4'(SIZE_W - 1);
                        mul_reg  <= '0;
                    end
                    else
                        my_reg <= mean_sat;
                end
            ST_FIN:
                if (out_free)
                begin
                    rsp_data_reg.box_total <= tot_sat;
                    rsp_data_reg.mean_x    <= mx_reg;
                    rsp_data_reg.mean_y    <= my_reg;
                end
            default:
                ;
        endcase

        p1_x_reg  <= wx_reg;
        p1_y_reg  <= wy_reg;
        p2_s_reg  <= rd_data_reg;
        p2_wx_reg <= PX_W'(rd_data_reg) * PX_W'({p1_x_reg, 1'b1});
        p2_wy_reg <= PY_W'(rd_data_reg) * PY_W'({p1_y_reg, 1'b1});

        if (state_reg == ST_ADDR)
        begin
            tot_reg <= '0;
            wsx_reg <= '0;
            wsy_reg <= '0;
        end
        else if (p2_valid_reg)
        begin
            tot_reg <= tot_reg + TOT_W'(p2_s_reg);
            wsx_reg <= wsx_reg + WS_W'(p2_wx_reg);
            wsy_reg <= wsy_reg + WS_W'(p2_wy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
            rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            mem[mem_wr_addr] <= mem_wr_data;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

`ifndef SYNTH
    a_walk_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !mem_wr_en)
        else $error("tile write during box walk");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_DIV_WAIT) || (state_reg == ST_MDIV_WAIT)))
        else $error("divider finished with no division pending");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && rsp_valid_reg && !rsp.ready) |=> (state_reg == ST_FIN))
        else $error("result dropped while output word still pending");

    a_mean_nonzero_total: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN) && (state_next == ST_MUL)) |-> (tot_reg != '0))
        else $error("mean computed on zero total");
`endif

endmodule

`default_nettype wire

FILE: tb/grid_deposit_region_centroid_core_tb.sv
// Self-checking bench for the tile strength grid core: box query results are
// checked against a behavioral tile grid in the bench that deposits update.
// Depends on gdrc_pkg, gdrc_if and grid_deposit_region_centroid_core.
`timescale 1ns / 1ps

module grid_deposit_region_centroid_core_tb;
    import gdrc_pkg::*;

    localparam int GW = GRID_WIDTH_DEF;
    localparam int GH = GRID_HEIGHT_DEF;
    localparam int NK = KINDS_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE = 400;

    logic clk;
    logic rst_n;

    gdrc_req_if req_ch ();
    gdrc_rsp_if rsp_ch ();
    gdrc_cfg_if cfg_ch ();

    grid_deposit_region_centroid_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    logic [31:0]        tile_mass [NK][GH][GW];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    req_word_t          pending_words [$];
    rsp_word_t          centroid_q [$];
    int                 idle_pct;
    int                 stall_pct;
    int                 hold_cnt;
    logic               hold_go;
    int                 mismatches;
    int                 cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int to_tile(logic signed [POS_W-1:0] pos, logic [SIZE_W-1:0] sz);
        int s;
        s = (sz == 0) ? 1 : int'(sz);
        return int'(pos) / s;
    endfunction

    function automatic logic [MEAN_W-1:0] weighted_mean(logic [63:0] wsum, logic [63:0] total,
                                                        logic [SIZE_W-1:0] sz);
        logic [127:0] num;
        logic [127:0] q;
        num = 128'(wsum) * ((sz == 0) ? 128'd1 : 128'(sz));
        q = num / (128'(total) * 2);
        return (q > 128'(MEAN_MAX)) ? MEAN_MAX : q[MEAN_W-1:0];
    endfunction

    task automatic apply_word(req_word_t w);
        int        lx, ly, rx, ry;
        logic [63:0] total, wx, wy, s;
        rsp_word_t r;
        lx = to_tile(w.x_a, width_reg);
        ly = to_tile(w.y_a, height_reg);
        if (w.op == OP_DEPOSIT)
        begin
            if (w.kind < NK && lx >= 0 && lx < GW && ly >= 0 && ly < GH)
            begin
                s = 64'(tile_mass[w.kind][ly][lx]) + 64'(w.strength);
                tile_mass[w.kind][ly][lx] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
            end
            return;
        end
        rx = to_tile(w.x_b, width_reg) + 1;
        ry = to_tile(w.y_b, height_reg) + 1;
        if (lx < 0) lx = 0;
        if (ly < 0) ly = 0;
        if (rx > GW) rx = GW;
        if (ry > GH) ry = GH;
        total = 0;
        wx = 0;
        wy = 0;
        if (w.kind < NK)
            for (int y = ly; y < ry; y++)
                for (int x = lx; x < rx; x++)
                begin
                    s = 64'(tile_mass[w.kind][y][x]);
                    total += s;
                    wx += s * 64'(2 * x + 1);
                    wy += s * 64'(2 * y + 1);
                end
        r.box_total = (total > 64'(TOTAL_MAX)) ? TOTAL_MAX : total[TOTAL_W-1:0];
        r.mean_x = (total == 0) ? '0 : weighted_mean(wx, total, width_reg);
        r.mean_y = (total == 0) ? '0 : weighted_mean(wy, total, height_reg);
        centroid_q.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                apply_word(req_ch.data);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_words.pop_front();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_go)
            hold_cnt <= 12000;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t e;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= (hold_cnt == 0) && !hold_go && ($urandom_range(99) >= stall_pct);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (centroid_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: total %0d mean %0d,%0d",
                                 rsp_ch.data.box_total, rsp_ch.data.mean_x,
                                 rsp_ch.data.mean_y);
                end
                else
                begin
                    e = centroid_q.pop_front();
                    if (e.box_total !== rsp_ch.data.box_total
                        || e.mean_x !== rsp_ch.data.mean_x || e.mean_y !== rsp_ch.data.mean_y)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp total %0d mean %0d,%0d",
                                      " got total %0d mean %0d,%0d"},
                                     e.box_total, e.mean_x, e.mean_y,
                                     rsp_ch.data.box_total, rsp_ch.data.mean_x,
                                     rsp_ch.data.mean_y);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("grid_deposit_region_centroid_core_tb: FAIL");
            $finish;
        end
    end

    function automatic req_word_t mk(logic op, int xa, int ya, int xb, int yb, int st, logic k);
        req_word_t w;
        w.op = op;
        w.x_a = xa[POS_W-1:0];
        w.y_a = ya[POS_W-1:0];
        w.x_b = xb[POS_W-1:0];
        w.y_b = yb[POS_W-1:0];
        w.strength = st[STR_W-1:0];
        w.kind = k;
        return w;
    endfunction

    function automatic int pos_in(int t, logic [SIZE_W-1:0] sz);
        int s, p;
        s = (sz == 0) ? 1 : int'(sz);
        p = t * s + $urandom_range(s - 1);
        return (p > 32767) ? 32767 : p;
    endfunction

    function automatic int max_tile(logic [SIZE_W-1:0] sz, int grid);
        int s, m;
        s = (sz == 0) ? 1 : int'(sz);
        m = 32767 / s;
        return (m > grid - 1) ? grid - 1 : m;
    endfunction

    function automatic req_word_t random_word();
        req_word_t w;
        logic [95:0] raw;
        int mx, my, tx, ty, bx, by, pick;
        mx = max_tile(width_reg, GW);
        my = max_tile(height_reg, GH);
        pick = $urandom_range(99);
        raw = {$urandom, $urandom, $urandom};
        w = raw[$bits(req_word_t)-1:0];
        if (pick < 10)
            return w;
        tx = $urandom_range(mx);
        ty = $urandom_range(my);
        if (pick < 60)
        begin
            w.op = OP_DEPOSIT;
            w.x_a = POS_W'(pos_in(tx, width_reg));
            w.y_a = POS_W'(pos_in(ty, height_reg));
            if ($urandom_range(3) == 0)
                w.strength = 16'hFFFF;
            return w;
        end
        w.op = OP_QUERY;
        if (pick < 63)
        begin
            w.x_a = 16'sh8000;
            w.y_a = 16'sh8000;
            w.x_b = 16'sh7FFF;
            w.y_b = 16'sh7FFF;
            return w;
        end
        bx = tx + $urandom_range(5);
        by = ty + $urandom_range(5);
        if (bx > mx) bx = mx;
        if (by > my) by = my;
        w.x_a = POS_W'(pos_in(tx, width_reg));
        w.y_a = POS_W'(pos_in(ty, height_reg));
        w.x_b = POS_W'(pos_in(bx, width_reg));
        w.y_b = POS_W'(pos_in(by, height_reg));
        return w;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_TILE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !req_ch.valid && centroid_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(int idle, int stall, logic [SIZE_W-1:0] w,
                             logic [SIZE_W-1:0] h, int mode);
        drain();
        idle_pct = idle;
        stall_pct = stall;
        write_reg(CFG_TILE_WIDTH, w);
        write_reg(CFG_TILE_HEIGHT, h);
        for (int i = 0; i < 24; i++)
        begin
            if (i == 8 && mode == 1)
            begin
                @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            if (i == 14 && mode == 2)
                wait (pending_words.size() == 0 && !req_ch.valid && centroid_q.size() == 0);
            pending_words.push_back(random_word());
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        hold_go = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        cycles = 0;
        width_reg = TILE_SIZE_RESET;
        height_reg = TILE_SIZE_RESET;
        foreach (tile_mass[k, y, x])
            tile_mass[k][y][x] = '0;
        clk = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        pending_words.push_back(mk(OP_QUERY, -32768, -32768, 32767, 32767, 0, 1'b0));
        pending_words.push_back(mk(OP_DEPOSIT, 0, 0, 5, 5, 65535, 1'b0));
        pending_words.push_back(mk(OP_DEPOSIT, -15, -9, 0, 0, 1, 1'b0));
        pending_words.push_back(mk(OP_DEPOSIT, 1023, 1023, -1, -1, 65535, 1'b0));
        pending_words.push_back(mk(OP_DEPOSIT, 1008, 5, 0, 0, 0, 1'b0));
        pending_words.push_back(mk(OP_DEPOSIT, 1024, 16, 0, 0, 777, 1'b0));
        pending_words.push_back(mk(OP_DEPOSIT, -32768, 32767, 0, 0, 999, 1'b1));
        pending_words.push_back(mk(OP_DEPOSIT, 32767, 40, 0, 0, 999, 1'b1));
        pending_words.push_back(mk(OP_DEPOSIT, 300, 500, 0, 0, 12345, 1'b1));
        pending_words.push_back(mk(OP_DEPOSIT, 310, 17, 0, 0, 40000, 1'b1));
        pending_words.push_back(mk(OP_QUERY, -32768, -32768, 32767, 32767, 0, 1'b0));
        pending_words.push_back(mk(OP_QUERY, -32768, -32768, 32767, 32767, 0, 1'b1));
        pending_words.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 1'b0));
        pending_words.push_back(mk(OP_QUERY, -5, -5, -1, -1, 0, 1'b0));
        pending_words.push_back(mk(OP_QUERY, 1008, 1008, 1023, 1023, 0, 1'b0));
        pending_words.push_back(mk(OP_QUERY, 500, 500, 100, 100, 0, 1'b1));
        pending_words.push_back(mk(OP_QUERY, 200, 200, 250, 250, 0, 1'b1));
        pending_words.push_back(mk(OP_QUERY, 300, 0, 320, 600, 65535, 1'b1));
        pending_words.push_back(mk(OP_QUERY, -32768, 32767, 32767, -32768, 0, 1'b0));

        run_phase(0, 0, 13'd16, 13'd16, 0);
        run_phase(72, 0, 13'd1, 13'd1, 0);
        run_phase(0, 72, 13'd0, 13'd8191, 1);
        run_phase(28, 28, 13'd4096, 13'd100, 0);
        run_phase(0, 0, 13'd5, 13'd3, 2);

        wait (pending_words.size() == 0 && !req_ch.valid && centroid_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && centroid_q.size() == 0)
            $display("grid_deposit_region_centroid_core_tb: PASS");
        else
            $display("grid_deposit_region_centroid_core_tb: FAIL");
        $finish;
    end

endmodule
